// ===== hdl/mfsg_pkg.sv =====
package mfsg_pkg;

    localparam int LANES     = 4;
    localparam int LANE_IDX_W = 2;
    localparam int CFG_IDX_W = 4;
    localparam int CFG_DATA_W = 16;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_ENABLED_MOTORS   = 4'd0,
        REG_MIN_TARGET_SPEED = 4'd1,
        REG_MIN_ACTUAL_SPEED = 4'd2,
        REG_STALL_TIMEOUT_MS = 4'd3
    } cfg_reg_t;

    localparam logic [3:0]  RST_ENABLED_MOTORS   = 4'd15;
    localparam logic [14:0] RST_MIN_TARGET_SPEED = 15'd50;
    localparam logic [14:0] RST_MIN_ACTUAL_SPEED = 15'd20;
    localparam logic [15:0] RST_STALL_TIMEOUT_MS = 16'd500;

    typedef struct packed {
        logic [14:0] min_target_speed;
        logic [14:0] min_actual_speed;
        logic [15:0] stall_timeout_ms;
    } cfg_t;

    // per-lane status bits for one check
    typedef struct packed {
        logic enabled;
        logic encoder_ok;
        logic drive_run;
        logic pwm_active;
    } lane_ctl_t;

    // |v| with -32768 mapping to 32768 exactly
    function automatic logic [16:0] magnitude17(input logic signed [15:0] v);
        logic [16:0] e;
        e = {v[15], v};
        return v[15] ? (~e + 17'd1) : e;
    endfunction

endpackage

// ===== hdl/mfsg_check_if.sv =====
interface mfsg_check_if;
    logic               valid;
    logic               ready;
    logic [31:0]        now_ms;
    logic [3:0]         speed_valid_mask;
    logic [3:0]         drive_run_mask;
    logic [3:0]         pwm_active_mask;
    logic signed [15:0] requested_speed_0;
    logic signed [15:0] requested_speed_1;
    logic signed [15:0] requested_speed_2;
    logic signed [15:0] requested_speed_3;
    logic signed [15:0] measured_speed_0;
    logic signed [15:0] measured_speed_1;
    logic signed [15:0] measured_speed_2;
    logic signed [15:0] measured_speed_3;

    modport source (
        output valid, now_ms, speed_valid_mask, drive_run_mask, pwm_active_mask,
        output requested_speed_0, requested_speed_1, requested_speed_2, requested_speed_3,
        output measured_speed_0, measured_speed_1, measured_speed_2, measured_speed_3,
        input  ready
    );
    modport sink (
        input  valid, now_ms, speed_valid_mask, drive_run_mask, pwm_active_mask,
        input  requested_speed_0, requested_speed_1, requested_speed_2, requested_speed_3,
        input  measured_speed_0, measured_speed_1, measured_speed_2, measured_speed_3,
        output ready
    );
endinterface

// ===== hdl/mfsg_result_if.sv =====
interface mfsg_result_if;
    logic       valid;
    logic       ready;
    logic       fault;
    logic [1:0] faulted_motor;

    modport source (output valid, fault, faulted_motor, input ready);
    modport sink (input valid, fault, faulted_motor, output ready);
endinterface

// ===== hdl/mfsg_cfg_if.sv =====
interface mfsg_cfg_if;
    logic                             valid;
    logic                             ready;
    logic [mfsg_pkg::CFG_IDX_W-1:0]  index;
    logic [mfsg_pkg::CFG_DATA_W-1:0] data;

    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

// ===== hdl/mfsg_lane.sv =====
module mfsg_lane (
    input  logic               clk,
    input  logic               rst_n,
    input  mfsg_pkg::cfg_t     cfg,
    input  mfsg_pkg::lane_ctl_t ctl,
    input  logic [31:0]        now_ms,
    input  logic signed [15:0] requested_speed,
    input  logic signed [15:0] measured_speed,
    input  logic               update,
    output logic               fault
);
    import mfsg_pkg::*;

    logic        watch_reg;
    logic        watch_next;
    logic [31:0] start_reg;
    logic [31:0] start_next;
    logic [16:0] req_mag;
    logic [16:0] act_mag;
    logic [31:0] elapsed;
    logic        stalled;
    logic        timed_out;

    assign req_mag   = magnitude17(requested_speed);
    assign act_mag   = magnitude17(measured_speed);
    assign elapsed   = now_ms - start_reg;
    assign timed_out = elapsed >= {16'd0, cfg.stall_timeout_ms};
    assign stalled   = (req_mag >= {2'd0, cfg.min_target_speed})
                     && (act_mag < {2'd0, cfg.min_actual_speed})
                     && ctl.drive_run && ctl.pwm_active;

    assign fault = ctl.enabled
                 && (!ctl.encoder_ok || (stalled && watch_reg && timed_out));

    always_comb
    begin
        watch_next = watch_reg;
        start_next = start_reg;
        if (!ctl.enabled)
        begin
            watch_next = 1'b0;
        end
        else if (ctl.encoder_ok)
        begin
            if (!stalled)
            begin
                watch_next = 1'b0;
            end
            else if (!watch_reg)
            begin
                // open the no-motion window at this check's time
                watch_next = 1'b1;
                start_next = now_ms;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            watch_reg <= 1'b0;
            start_reg <= 32'd0;
        end
        else if (update)
        begin
            watch_reg <= watch_next;
            start_reg <= start_next;
        end
    end

endmodule

// ===== hdl/motor_feedback_stall_guard.sv =====
// Channel  Role   Payload
// check    sink   now_ms, valid/run/pwm masks, requested_speed_0..3, measured_speed_0..3
// result   source fault, faulted_motor
// cfg      sink   index, data (register write, always ready)
//
// One check per cycle sustained while result.ready is high; results are registered.
// Input register feeds four parallel lane evaluators; one 32-bit subtract/compare per lane
// sets the path to the result register.
// rst_n clears watch state and pipeline valids and sets config registers to reset values.
// A stalled result holds; the input register takes a check during the stall only if empty.
module motor_feedback_stall_guard #(
    parameter int MOTOR_COUNT = 4
) (
    input logic          clk,
    input logic          rst_n,
    mfsg_check_if.sink   check,
    mfsg_result_if.source result,
    mfsg_cfg_if.sink     cfg
);
    import mfsg_pkg::*;

    logic [3:0]         enabled_reg;
    cfg_t               cfg_reg;

    logic               in_valid_reg;
    logic [31:0]        now_reg;
    logic [3:0]         svalid_reg;
    logic [3:0]         run_reg;
    logic [3:0]         pwm_reg;
    logic signed [15:0] req_reg [LANES];
    logic signed [15:0] act_reg [LANES];

    logic               out_valid_reg;
    logic               fault_reg;
    logic [1:0]         motor_reg;

    logic               advance;
    logic               fault_next;
    logic [1:0]         motor_next;
    logic [MOTOR_COUNT-1:0] lane_fault;
    logic [MOTOR_COUNT-1:0] lane_update;

    assign cfg.ready     = 1'b1;
    assign advance       = in_valid_reg && (!out_valid_reg || result.ready);
    assign check.ready   = !in_valid_reg || advance;
    assign result.valid  = out_valid_reg;
    assign result.fault  = fault_reg;
    assign result.faulted_motor = motor_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            enabled_reg              <= RST_ENABLED_MOTORS;
            cfg_reg.min_target_speed <= RST_MIN_TARGET_SPEED;
            cfg_reg.min_actual_speed <= RST_MIN_ACTUAL_SPEED;
            cfg_reg.stall_timeout_ms <= RST_STALL_TIMEOUT_MS;
        end
        else if (cfg.valid)
        begin
            unique case (cfg.index)
                REG_ENABLED_MOTORS:   enabled_reg              <= cfg.data[3:0];
                REG_MIN_TARGET_SPEED: cfg_reg.min_target_speed <= cfg.data[14:0];
                REG_MIN_ACTUAL_SPEED: cfg_reg.min_actual_speed <= cfg.data[14:0];
                REG_STALL_TIMEOUT_MS: cfg_reg.stall_timeout_ms <= cfg.data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (check.ready)
        begin
            in_valid_reg <= check.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (check.valid && check.ready)
        begin
            now_reg    <= check.now_ms;
            svalid_reg <= check.speed_valid_mask;
            run_reg    <= check.drive_run_mask;
            pwm_reg    <= check.pwm_active_mask;
            req_reg[0] <= check.requested_speed_0;
            req_reg[1] <= check.requested_speed_1;
            req_reg[2] <= check.requested_speed_2;
            req_reg[3] <= check.requested_speed_3;
            act_reg[0] <= check.measured_speed_0;
            act_reg[1] <= check.measured_speed_1;
            act_reg[2] <= check.measured_speed_2;
            act_reg[3] <= check.measured_speed_3;
        end
    end

    for (genvar i = 0; i < MOTOR_COUNT; i++)
    begin : g_lane
        lane_ctl_t ctl;

        assign ctl.enabled     = enabled_reg[i];
        assign ctl.encoder_ok  = svalid_reg[i];
        assign ctl.drive_run   = run_reg[i];
        assign ctl.pwm_active  = pwm_reg[i];

        mfsg_lane u_lane (
            .clk             (clk),
            .rst_n           (rst_n),
            .cfg             (cfg_reg),
            .ctl             (ctl),
            .now_ms          (now_reg),
            .requested_speed (req_reg[i]),
            .measured_speed  (act_reg[i]),
            .update          (lane_update[i]),
            .fault           (lane_fault[i])
        );
    end

    // first faulting lane stops the scan; lanes after it hold their state
    always_comb
    begin
        logic blocked;
        blocked    = 1'b0;
        fault_next = 1'b0;
        motor_next = '0;
        for (int i = 0; i < MOTOR_COUNT; i++)
        begin
            lane_update[i] = advance && !blocked;
            if (lane_fault[i] && !blocked)
            begin
                fault_next = 1'b1;
                motor_next = LANE_IDX_W'(i);
            end
            blocked = blocked | lane_fault[i];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (result.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            fault_reg <= fault_next;
            motor_reg <= motor_next;
        end
    end

    a_idle_motor_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !fault_reg) |-> (motor_reg == 2'd0))
        else $error("faulted_motor nonzero without fault");

    a_motor_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && fault_reg) |-> (32'(motor_reg) < MOTOR_COUNT))
        else $error("faulted_motor names an unfitted lane");

    a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid_reg |-> check.ready)
        else $error("check blocked with empty result register");

    a_hold_stage: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid_reg && out_valid_reg && !result.ready) |=> in_valid_reg)
        else $error("pending check dropped during result stall");

endmodule
